FILE: rtl/core/go_back_n_sender_window_defines.svh
// Assertion macros shared by the sender window checks.
`ifndef GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_DEFINES_SVH

// Same-cycle implication, clocked on clk, quiet while arst_n is low.
`define GBN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, quiet while arst_n is low.
`define GBN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/gbn_pkg.sv
// Types and constants of the go-back-n sender window.
package gbn_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int SEQ_BITS   = 16;
	localparam int WIN_W      = 7;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	localparam logic [1:0] REQ_START   = 2'd0;
	localparam logic [1:0] REQ_ACK     = 2'd1;
	localparam logic [1:0] REQ_TIMEOUT = 2'd2;

	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_TOTAL  = 1'b1;

	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);

	typedef struct packed {
		logic [1:0]          req_type;
		logic [SEQ_BITS-1:0] ack_number;
	} req_t;

	typedef struct packed {
		logic [SEQ_BITS-1:0] frame_seq;
		logic                send_valid;
		logic                last;
		logic                all_done;
		logic [SEQ_BITS-1:0] window_base;
	} res_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic calc;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic last_beat;
	} dp_status_t;

endpackage

FILE: rtl/core/gbn_regs.sv
// APB register file: window size and frame total.
module gbn_regs
	import gbn_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	output logic [WIN_W-1:0]    window_size,
	output logic [SEQ_BITS-1:0] total_frames
);

	logic [WIN_W-1:0]    window_q;
	logic [SEQ_BITS-1:0] total_q;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			total_q  <= '0;
		end else if (wr_en) begin
			if (paddr[2] == REG_WINDOW) begin
				window_q <= pwdata[WIN_W-1:0];
			end else begin
				total_q <= pwdata[SEQ_BITS-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_WINDOW) begin
			prdata = DATA_W'(window_q);
		end else begin
			prdata = DATA_W'(total_q);
		end
	end

	assign window_size  = window_q;
	assign total_frames = total_q;

endmodule

FILE: rtl/core/gbn_ctrl.sv
// Sequencer: takes one event, updates the window, then streams its beats.
module gbn_ctrl
	import gbn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_UPDATE = 4'b0010,
		ST_LIMIT  = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.update  = 1'b0;
		cmd.calc    = 1'b0;
		cmd.emit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_LIMIT;
			end
			ST_LIMIT: begin
				cmd.calc = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.slot_free) begin
					cmd.emit = 1'b1;
					if (status.last_beat) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/core/gbn_dp.sv
// Window datapath: base/next counters, send limit and the result register.
module gbn_dp
	import gbn_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  req_t                req,
	input  logic [WIN_W-1:0]    window_size,
	input  logic [SEQ_BITS-1:0] total_frames,
	input  dp_cmd_t             cmd,
	output dp_status_t          status,
	output logic                res_valid,
	input  logic                res_stall,
	output res_t                res
);

	req_t                req_q;
	logic [SEQ_BITS-1:0] base_q;
	logic [SEQ_BITS-1:0] next_q;
	logic [SEQ_BITS:0]   limit_q;
	logic                done_q;
	res_t                res_q;
	logic                res_valid_q;

	logic [SEQ_BITS:0]   ack_inc;
	logic [SEQ_BITS-1:0] cand;
	logic [WIN_W-1:0]    win_eff;
	logic [SEQ_BITS:0]   limit_raw;
	logic [SEQ_BITS:0]   next_ext;
	logic [SEQ_BITS:0]   next_inc;

	// ack + 1, held to the frame total
	assign ack_inc = {1'b0, req_q.ack_number} + (SEQ_BITS+1)'(1);
	assign cand    = (ack_inc > {1'b0, total_frames}) ? total_frames
	                                                  : ack_inc[SEQ_BITS-1:0];

	always_comb begin
		if (window_size == '0) begin
			win_eff = WIN_W'(1);
		end else if (window_size > WIN_W'(MAX_WINDOW)) begin
			win_eff = WIN_W'(MAX_WINDOW);
		end else begin
			win_eff = window_size;
		end
	end

	assign limit_raw = {1'b0, base_q} + (SEQ_BITS+1)'(win_eff);
	assign next_ext  = {1'b0, next_q};
	assign next_inc  = next_ext + (SEQ_BITS+1)'(1);

	assign status.slot_free = !res_valid_q || !res_stall;
	assign status.last_beat = (next_inc >= limit_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.calc) begin
			limit_q <= (limit_raw > {1'b0, total_frames}) ? {1'b0, total_frames} : limit_raw;
			done_q  <= (base_q >= total_frames);
		end
		if (cmd.emit) begin
			res_q.window_base <= base_q;
			res_q.all_done    <= done_q;
			if (next_ext < limit_q) begin
				res_q.frame_seq  <= next_q;
				res_q.send_valid <= 1'b1;
				res_q.last       <= (next_inc >= limit_q);
			end else begin
				// nothing allowed: a single status beat
				res_q.frame_seq  <= '0;
				res_q.send_valid <= 1'b0;
				res_q.last       <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			next_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				case (req_q.req_type)
					REQ_ACK: begin
						// stale or end-clamped acks that do not advance are dropped
						if (cand > base_q) begin
							base_q <= cand;
							if (next_q < cand) begin
								next_q <= cand;
							end
						end
					end
					REQ_TIMEOUT: begin
						next_q <= base_q;
					end
					default: begin
					end
				endcase
			end else if (cmd.emit && (next_ext < limit_q)) begin
				next_q <= next_inc[SEQ_BITS-1:0];
			end

			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: rtl/core/go_back_n_sender_window.sv
// Each accepted event steps through update, limit and emit; res_valid rises when the first
// beat is loaded in emit, then one beat a cycle while res is not stalled.
// No new event is taken until the last beat is loaded. beats is 1 to 64, set by the
// base, window_size, total_frames and next_seq; the sequencer walks next_seq up to the limit.
// Reset (arst_n low, asynchronous): base and next sequence 0, window_size 4, total_frames 0,
// sequencer idle, no result pending.
module go_back_n_sender_window
	import gbn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// event channel
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	// result channel
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res,
	// APB configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [WIN_W-1:0]    window_size;
	logic [SEQ_BITS-1:0] total_frames;
	dp_cmd_t             cmd;
	dp_status_t          status;

	// Config registers; the user must write them only while no event is in flight (not enforced).
	gbn_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.window_size  (window_size),
		.total_frames (total_frames)
	);

	// Sequencer: one event at a time. req_stall is high from the capture edge until
	// the final beat of the event has been loaded into the result register.
	gbn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: the result register decouples the two channels, so a new event is
	// taken while the last beat of the previous one is still waiting downstream.
	gbn_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.window_size  (window_size),
		.total_frames (total_frames),
		.cmd          (cmd),
		.status       (status),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res          (res)
	);

endmodule

FILE: rtl/core/gbn_checker.sv
// Port-level checks on the sender window, bound to the top level.
`include "go_back_n_sender_window_defines.svh"

module gbn_checker
	import gbn_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	`GBN_ASSERT_NOW(a_status_is_last, res_valid && !res.send_valid, res.last, "status beat without last")
	`GBN_ASSERT_NOW(a_status_seq_zero, res_valid && !res.send_valid, res.frame_seq == '0, "status beat with nonzero frame_seq")
	`GBN_ASSERT_NOW(a_seq_in_window, res_valid && res.send_valid, (res.frame_seq >= res.window_base) && ({1'b0, res.frame_seq} < ({1'b0, res.window_base} + (SEQ_BITS+1)'(MAX_WINDOW))), "frame outside window")
	`GBN_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "stalled result beat changed")

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

FILE: bench/go_back_n_sender_window_test.sv
// Self-checking bench for the go-back-n sender window: event stimulus, result checks, APB setup.
`timescale 1ns / 1ps

module go_back_n_sender_window_test;
	import gbn_pkg::*;

	// event code 3 is unused by the block and behaves as start/resume
	localparam logic [1:0] REQ_SPARE      = 2'd3;
	localparam int         HOLD_CYCLES    = 400;   // long receiver hold-off
	localparam int         WATCHDOG_LIMIT = 4000;  // cycles with no event, beat or APB access
	localparam int         SEQ_TOP        = (1 << SEQ_BITS) - 1;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_t              req       = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	res_t              res;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	go_back_n_sender_window uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Events waiting to be offered, and the frame beats the window should emit.
	req_t event_q[$];
	res_t frame_q[$];

	// Shadow of the window state and of the two registers.
	int unsigned base_seq_pred = 0;
	int unsigned next_seq_pred = 0;
	int unsigned window_cfg    = 4;
	int unsigned total_cfg     = 0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_trigger  = 1'b0;
	bit hold_used     = 1'b0;
	int hold_cnt      = 0;

	int mismatches    = 0;
	int events_taken  = 0;
	int beats_checked = 0;
	int frames_sent   = 0;
	int quiet_cycles  = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Apply one event to the shadow window and queue every beat it should cause.
	function automatic void advance_window(input req_t ev);
		int unsigned cand;
		int unsigned lim;
		int unsigned win;
		int          beats;
		logic        done;
		res_t        beat;
		beats = 0;
		case (ev.req_type)
			REQ_ACK: begin
				// cumulative ack: base moves to ack + 1, capped at the transfer end;
				// a stale ack never pulls the base back
				cand = ev.ack_number + 1;
				if (cand > total_cfg)
					cand = total_cfg;
				if (cand > base_seq_pred) begin
					base_seq_pred = cand;
					if (next_seq_pred < base_seq_pred)
						next_seq_pred = base_seq_pred;
				end
			end
			REQ_TIMEOUT: next_seq_pred = base_seq_pred;
			default: ;  // start/resume and the spare code leave the state alone
		endcase
		// window 0 acts as 1, anything above the maximum as the maximum
		win = window_cfg;
		if (win < 1)
			win = 1;
		if (win > MAX_WINDOW)
			win = MAX_WINDOW;
		lim = base_seq_pred + win;
		if (lim > total_cfg)
			lim = total_cfg;
		done = (base_seq_pred >= total_cfg);
		while (next_seq_pred < lim && beats < MAX_WINDOW) begin
			beat.frame_seq   = SEQ_BITS'(next_seq_pred);
			beat.send_valid  = 1'b1;
			beat.last        = (next_seq_pred + 1 >= lim) || (beats + 1 >= MAX_WINDOW);
			beat.all_done    = done;
			beat.window_base = SEQ_BITS'(base_seq_pred);
			frame_q.push_back(beat);
			next_seq_pred = (next_seq_pred + 1) & SEQ_TOP;
			beats++;
		end
		// nothing allowed out: a single status beat
		if (beats == 0) begin
			beat.frame_seq   = '0;
			beat.send_valid  = 1'b0;
			beat.last        = 1'b1;
			beat.all_done    = done;
			beat.window_base = SEQ_BITS'(base_seq_pred);
			frame_q.push_back(beat);
		end
	endfunction

	function automatic void post_event(input logic [1:0] kind, input logic [SEQ_BITS-1:0] ack);
		req_t ev;
		ev.req_type   = kind;
		ev.ack_number = ack;
		event_q.push_back(ev);
	endfunction

	// Mostly acks near the live window so the base keeps creeping up; a few stale
	// or wild acks, resumes, timeouts and the spare code. The unused ack field of
	// non-ack events carries random bits.
	function automatic req_t pick_event();
		req_t        ev;
		int unsigned roll;
		int unsigned lo;
		int unsigned hi;
		roll          = $urandom_range(99);
		ev.ack_number = SEQ_BITS'($urandom);
		if (roll < 56) begin
			ev.req_type = REQ_ACK;
			lo = (base_seq_pred >= 3) ? base_seq_pred - 3 : 0;
			hi = next_seq_pred + 1;
			if (hi > SEQ_TOP - 1)
				hi = SEQ_TOP - 1;
			if (lo > hi)
				lo = hi;
			ev.ack_number = SEQ_BITS'($urandom_range(hi, lo));
		end else if (roll < 59) begin
			ev.req_type   = REQ_ACK;
			ev.ack_number = SEQ_BITS'($urandom_range(base_seq_pred, 0));
		end else if (roll < 60) begin
			ev.req_type = REQ_ACK;  // wild ack, usually runs the transfer to its end
		end else if (roll < 80) begin
			ev.req_type = REQ_START;
		end else if (roll < 95) begin
			ev.req_type = REQ_TIMEOUT;
		end else begin
			ev.req_type = REQ_SPARE;
		end
		return ev;
	endfunction

	function automatic logic [DATA_W-1:0] pick_window();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return DATA_W'($urandom_range(8, 1));
		if (roll < 92)
			return DATA_W'($urandom_range(64, 9));
		case ($urandom_range(3))
			0:       return DATA_W'(0);
			1:       return DATA_W'(MAX_WINDOW);
			2:       return DATA_W'(100);
			default: return DATA_W'(127);
		endcase
	endfunction

	// APB write (setup + access), then read back through the same port.
	task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] stored;
		stored = (idx == REG_WINDOW) ? (value & 32'h7F) : (value & 32'hFFFF);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);  // register takes the value at this edge
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_WINDOW)
			window_cfg = stored;
		else
			total_cfg = stored;
		@(posedge clk);
		psel    <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== stored) begin
			$error("prdata: expected %0d, got %0d", stored, prdata);
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Keeps the pending queue short so acks are picked against a fresh shadow.
	task automatic feed_events(input int count);
		repeat (count) begin
			while (event_q.size() >= 2)
				@(negedge clk);
			event_q.push_back(pick_event());
		end
	endtask

	// Sender holds back until every event is taken and every beat is in.
	task automatic wait_idle();
		@(negedge clk);
		while (event_q.size() != 0 || req_valid || frame_q.size() != 0)
			@(negedge clk);
	endtask

	// Event driver: payload holds while stalled, random gaps between events.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				advance_window(req);
				events_taken++;
			end
			if (!req_valid || !req_stall) begin
				if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req       <= event_q.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Result back-pressure: random stalls plus one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			hold_cnt  <= 0;
			hold_used <= 1'b0;
		end else if (hold_cnt != 0) begin
			res_stall <= 1'b1;
			hold_cnt  <= hold_cnt - 1;
		end else if (hold_trigger && !hold_used) begin
			res_stall <= 1'b1;
			hold_cnt  <= HOLD_CYCLES - 1;
			hold_used <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Result monitor: every accepted beat against the oldest expected one.
	always @(posedge clk) begin : check_beats
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			beats_checked++;
			if (frame_q.size() == 0) begin
				$error("unexpected result beat: frame_seq %0d send_valid %0b",
					res.frame_seq, res.send_valid);
				mismatches++;
			end else begin
				want = frame_q.pop_front();
				if (want.send_valid)
					frames_sent++;
				if (res.frame_seq !== want.frame_seq) begin
					$error("frame_seq: expected %0d, got %0d", want.frame_seq, res.frame_seq);
					mismatches++;
				end
				if (res.send_valid !== want.send_valid) begin
					$error("send_valid: expected %0b, got %0b", want.send_valid, res.send_valid);
					mismatches++;
				end
				if (res.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, res.last);
					mismatches++;
				end
				if (res.all_done !== want.all_done) begin
					$error("all_done: expected %0b, got %0b", want.all_done, res.all_done);
					mismatches++;
				end
				if (res.window_base !== want.window_base) begin
					$error("window_base: expected %0d, got %0d",
						want.window_base, res.window_base);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: too long without any event, beat or register access means a hang.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((req_valid && !req_stall) || (res_valid && !res_stall) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned top;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: empty transfer, so only status beats with all_done.
		post_event(REQ_START, '0);
		post_event(REQ_ACK, '0);
		wait_idle();

		// Small transfer, window 4: first burst, slide, stale ack, resend,
		// spare code, then an ack past the end saturating at the total.
		write_reg(REG_TOTAL, 10);
		post_event(REQ_START, '0);
		post_event(REQ_ACK, 16'd1);
		post_event(REQ_ACK, 16'd0);
		post_event(REQ_TIMEOUT, '0);
		post_event(REQ_SPARE, 16'hFFFF);
		post_event(REQ_ACK, 16'd6);
		post_event(REQ_ACK, 16'hFFFF);
		wait_idle();

		// Window 0 behaves as one frame in flight.
		write_reg(REG_WINDOW, 0);
		write_reg(REG_TOTAL, 14);
		post_event(REQ_START, '0);
		post_event(REQ_ACK, 16'd10);
		post_event(REQ_TIMEOUT, '0);
		wait_idle();

		// Window above the maximum is clamped: long bursts.
		write_reg(REG_WINDOW, 127);
		write_reg(REG_TOTAL, 200);
		post_event(REQ_START, '0);
		post_event(REQ_ACK, 16'd20);
		wait_idle();

		// Total pulled below next, then below base: nothing goes out.
		write_reg(REG_TOTAL, 50);
		post_event(REQ_START, '0);
		wait_idle();
		write_reg(REG_TOTAL, 15);
		post_event(REQ_START, '0);
		post_event(REQ_ACK, 16'd100);
		wait_idle();

		write_reg(REG_WINDOW, MAX_WINDOW);
		write_reg(REG_TOTAL, 400);
		post_event(REQ_TIMEOUT, '0);
		wait_idle();

		// Random part in three idling regimes, fresh settings every few dozen
		// events; the long hold-off lands at the start of the no-idle regime.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 72 : 0;
			recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 24 : 0;
			for (int sub = 0; sub < 3; sub++) begin
				top = base_seq_pred + $urandom_range(1500, 100);
				if (top > SEQ_TOP)
					top = SEQ_TOP;
				write_reg(REG_WINDOW, pick_window());
				write_reg(REG_TOTAL, top);
				@(negedge clk);
				if (phase == 2 && sub == 0)
					hold_trigger = 1'b1;
				feed_events(27);
				wait_idle();
			end
		end

		// Top of the sequence space: bursts up to the last number, base reaching
		// the end, an ack of all ones, then an empty transfer.
		write_reg(REG_WINDOW, MAX_WINDOW);
		write_reg(REG_TOTAL, SEQ_TOP);
		post_event(REQ_ACK, 16'd65499);
		post_event(REQ_ACK, 16'd65533);
		post_event(REQ_TIMEOUT, '0);
		post_event(REQ_ACK, 16'd65534);
		post_event(REQ_ACK, 16'hFFFF);
		wait_idle();
		write_reg(REG_TOTAL, 0);
		post_event(REQ_START, '0);
		wait_idle();

		// allow for any stray beat after the last expected one
		repeat (20) @(posedge clk);

		$display("Run covered %0d events and %0d result beats, %0d of them frames to send,",
			events_taken, beats_checked, frames_sent);
		$display("across window and total settings from empty to the full sequence range.");
		if (mismatches == 0 && frame_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
